FILE: design/md4_pkg.sv
// Types, constants and round helper functions for the MD4 digest engine.
package md4_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_PAD,
        S_ZERO,
        S_LEN_LO,
        S_LEN_HI,
        S_OUT
    } t_state;

    localparam logic [31:0] IV_A     = 32'h67452301;
    localparam logic [31:0] IV_B     = 32'hEFCDAB89;
    localparam logic [31:0] IV_C     = 32'h98BADCFE;
    localparam logic [31:0] IV_D     = 32'h10325476;
    localparam logic [31:0] K_ROUND2 = 32'h5A827999;
    localparam logic [31:0] K_ROUND3 = 32'h6ED9EBA1;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LAST_ROUND = 6'd47;
    localparam logic [3:0]  LAST_SLOT  = 4'd15;
    localparam logic [3:0]  LEN_SLOT   = 4'd14;
    localparam logic [3:0]  LEN_SLOT_HI = 4'd15;
    localparam logic [2:0]  FULL_BYTES = 3'd4;

    function automatic logic [4:0] rot_amt(input logic [5:0] r);
        logic [4:0] s;
        s = 5'd3;
        unique case (r[5:4])
            2'd0: begin
                unique case (r[1:0])
                    2'd0: s = 5'd3;
                    2'd1: s = 5'd7;
                    2'd2: s = 5'd11;
                    2'd3: s = 5'd19;
                endcase
            end
            2'd1: begin
                unique case (r[1:0])
                    2'd0: s = 5'd3;
                    2'd1: s = 5'd5;
                    2'd2: s = 5'd9;
                    2'd3: s = 5'd13;
                endcase
            end
            default: begin
                unique case (r[1:0])
                    2'd0: s = 5'd3;
                    2'd1: s = 5'd9;
                    2'd2: s = 5'd11;
                    2'd3: s = 5'd15;
                endcase
            end
        endcase
        return s;
    endfunction

    function automatic logic [3:0] word_pick(input logic [5:0] r);
        logic [3:0] w;
        unique case (r[5:4])
            2'd0:    w = r[3:0];
            2'd1:    w = {r[1:0], r[3:2]};
            default: w = {r[0], r[1], r[2], r[3]};
        endcase
        return w;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
        logic [5:0] rs;
        rs = 6'd32 - {1'b0, s};
        return (v << s) | (v >> rs);
    endfunction

    // final partial word: keep the valid bytes, pad byte in the first free one
    function automatic logic [31:0] pad_word(input logic [31:0] w, input logic [1:0] vb);
        logic [31:0] p;
        unique case (vb)
            2'd0: p = {24'h0, PAD_BYTE};
            2'd1: p = {16'h0, PAD_BYTE, w[7:0]};
            2'd2: p = {8'h0, PAD_BYTE, w[15:0]};
            2'd3: p = {PAD_BYTE, w[23:0]};
        endcase
        return p;
    endfunction

endpackage

FILE: design/md4_hash_engine_unit.sv
// MD4 digest engine: block buffer, shared round unit, padding sequencer.
// The sixteenth word of a block starts a compression of 48 rounds.
// A final request writes padding and the bit length into the block, runs one or two compressions,
// then gives four digest results, one per accepted output cycle.
// Words are taken only while idle, never during rounds or padding; a block is 16 words and 48 rounds.
// Reset (synchronous, active low): chain to MD4 initial values, counts zero, sequencer idle.
module md4_hash_engine_unit
    import md4_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_final_item,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_last_word
);

    t_state      r_state, n_state;
    logic [5:0]  r_round;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] r_chain [4];
    logic [31:0] r_blk [16];
    logic [31:0] r_blk_word;
    logic [3:0]  r_fill;
    logic [60:0] r_bytes;
    logic        r_final, r_need_pad, r_len_done;
    logic [1:0]  r_idx;

    logic        accept, vb_full;
    logic [2:0]  add_bytes;
    logic        w_en;
    logic [3:0]  w_addr;
    logic [31:0] w_data;
    logic [31:0] f_val, k_val, sum, t_rot;
    logic        round_end;

    assign accept    = i_valid && o_ready;
    assign vb_full   = i_valid_bytes >= FULL_BYTES;
    assign round_end = (r_state == S_ROUND) && (r_round == LAST_ROUND);
    assign add_bytes = (!i_final_item || vb_full) ? FULL_BYTES : i_valid_bytes;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (r_fill == LAST_SLOT) begin
                        n_state = S_ROUND;
                    end else if (!i_final_item) begin
                        n_state = S_IDLE;
                    end else if (vb_full) begin
                        n_state = S_PAD;
                    end else begin
                        n_state = S_ZERO;
                    end
                end
            end
            S_ROUND: begin
                if (r_round == LAST_ROUND) begin
                    priority if (!r_final) n_state = S_IDLE;
                    else if (r_len_done)   n_state = S_OUT;
                    else if (r_need_pad)   n_state = S_PAD;
                    else                   n_state = S_ZERO;
                end
            end
            S_PAD: begin
                n_state = (r_fill == LAST_SLOT) ? S_ROUND : S_ZERO;
            end
            S_ZERO: begin
                priority if (r_fill == LAST_SLOT) n_state = S_ROUND;
                else if (r_fill == LEN_SLOT)     n_state = S_LEN_LO;
                else                             n_state = S_ZERO;
            end
            S_LEN_LO: n_state = S_LEN_HI;
            S_LEN_HI: n_state = S_ROUND;
            S_OUT: begin
                if (i_ready && r_idx == 2'd3) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_ready       = (r_state == S_IDLE);
        o_valid       = (r_state == S_OUT);
        o_digest_word = r_chain[r_idx];
        o_word_index  = r_idx;
        o_last_word   = (r_idx == 2'd3);
    end

    // block buffer write port
    always_comb begin
        w_en   = 1'b0;
        w_addr = r_fill;
        w_data = 32'h0;
        unique case (r_state)
            S_IDLE: begin
                w_en   = accept;
                w_data = (i_final_item && !vb_full) ?
                         pad_word(i_data_word, i_valid_bytes[1:0]) : i_data_word;
            end
            S_PAD: begin
                w_en   = 1'b1;
                w_data = {24'h0, PAD_BYTE};
            end
            S_ZERO: begin
                w_en   = 1'b1;
            end
            S_LEN_LO: begin
                w_en   = 1'b1;
                w_addr = LEN_SLOT;
                w_data = {r_bytes[28:0], 3'b000};
            end
            S_LEN_HI: begin
                w_en   = 1'b1;
                w_addr = LEN_SLOT_HI;
                w_data = r_bytes[60:29];
            end
            default: w_en = 1'b0;
        endcase
    end

    // round unit
    always_comb begin
        unique case (r_round[5:4])
            2'd0: begin
                f_val = (r_b & r_c) | (~r_b & r_d);
                k_val = 32'h0;
            end
            2'd1: begin
                f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
                k_val = K_ROUND2;
            end
            default: begin
                f_val = r_b ^ r_c ^ r_d;
                k_val = K_ROUND3;
            end
        endcase
        sum   = r_a + f_val + k_val + r_blk_word;
        t_rot = rotl32(sum, rot_amt(r_round));
    end

    // message word for the coming round is prefetched into a register (word 0 outside the rounds)
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_blk[w_addr] <= w_data;
        end
        r_blk_word <= r_blk[word_pick((r_state == S_ROUND) ? r_round + 6'd1 : 6'd0)];
        if (r_state == S_ROUND) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= t_rot;
        end else begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_round    <= 6'd0;
            r_chain[0] <= IV_A;
            r_chain[1] <= IV_B;
            r_chain[2] <= IV_C;
            r_chain[3] <= IV_D;
            r_fill     <= 4'd0;
            r_bytes    <= 61'd0;
            r_final    <= 1'b0;
            r_need_pad <= 1'b0;
            r_len_done <= 1'b0;
            r_idx      <= 2'd0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_fill     <= r_fill + 4'd1;
                        r_bytes    <= r_bytes + 61'(add_bytes);
                        r_final    <= i_final_item;
                        r_need_pad <= i_final_item && vb_full && (r_fill == LAST_SLOT);
                    end
                end
                S_ROUND: begin
                    r_round <= round_end ? 6'd0 : r_round + 6'd1;
                    if (round_end) begin
                        r_chain[0] <= r_chain[0] + r_d;
                        r_chain[1] <= r_chain[1] + t_rot;
                        r_chain[2] <= r_chain[2] + r_b;
                        r_chain[3] <= r_chain[3] + r_c;
                    end
                end
                S_PAD: begin
                    r_fill     <= r_fill + 4'd1;
                    r_need_pad <= 1'b0;
                end
                S_ZERO: begin
                    if (r_fill != LEN_SLOT) begin
                        r_fill <= r_fill + 4'd1;
                    end
                end
                S_LEN_LO: begin
                    r_fill <= LEN_SLOT_HI;
                end
                S_LEN_HI: begin
                    r_fill     <= 4'd0;
                    r_len_done <= 1'b1;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_idx <= r_idx + 2'd1;
                        if (r_idx == 2'd3) begin
                            r_chain[0] <= IV_A;
                            r_chain[1] <= IV_B;
                            r_chain[2] <= IV_C;
                            r_chain[3] <= IV_D;
                            r_fill     <= 4'd0;
                            r_bytes    <= 61'd0;
                            r_final    <= 1'b0;
                            r_need_pad <= 1'b0;
                            r_len_done <= 1'b0;
                        end
                    end
                end
                default: r_round <= 6'd0;
            endcase
        end
    end

endmodule
